// ----- design/bdpc_pkg.sv -----
// Shared types and constants for the button debounce and press classifier.
package bdpc_pkg;

    localparam int NOW_W       = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int EVENT_W     = 2;
    localparam int TIME_BITS_DEF = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd30;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd3000;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'b1;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
    } t_cfg;

endpackage

// ----- design/bdpc_in_if.sv -----
// Poll channel: timestamp and raw pin level.
interface bdpc_in_if;
    logic                          valid;
    logic                          ready;
    logic [bdpc_pkg::NOW_W-1:0]    now_ms;
    logic                          pin_level;

    modport source (output valid, output now_ms, output pin_level, input ready);
    modport sink   (input valid, input now_ms, input pin_level, output ready);
endinterface

// ----- design/bdpc_out_if.sv -----
// Event channel: one press classification per poll.
interface bdpc_out_if;
    logic                          valid;
    logic                          ready;
    logic [bdpc_pkg::EVENT_W-1:0]  press_event;

    modport source (output valid, output press_event, input ready);
    modport sink   (input valid, input press_event, output ready);
endinterface

// ----- design/bdpc_cfg_regs.sv -----
// Configuration registers: debounce and long-press times.
module bdpc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bdpc_pkg::CFG_W-1:0]        i_cfg_wdata,
    output bdpc_pkg::t_cfg                    o_cfg
);

    bdpc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= bdpc_pkg::DEBOUNCE_RST;
            r_cfg.long_press_ms <= bdpc_pkg::LONG_PRESS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bdpc_pkg::CFG_DEBOUNCE:   r_cfg.debounce_ms   <= i_cfg_wdata;
                bdpc_pkg::CFG_LONG_PRESS: r_cfg.long_press_ms <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/bdpc_core.sv -----
// Poll register, debounce/press state, classifier and event register.
module bdpc_core #(
    parameter int TIME_BITS = bdpc_pkg::TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bdpc_pkg::t_cfg       i_cfg,
    bdpc_in_if.sink              i_in_ch,
    bdpc_out_if.source           o_out_ch
);

    // poll register
    logic                          r_in_valid;
    logic [bdpc_pkg::NOW_W-1:0]    r_in_now;
    logic                          r_in_pin;

    // classifier state
    logic                  r_last;
    logic [TIME_BITS-1:0]  r_change;
    logic                  r_held;
    logic [TIME_BITS-1:0]  r_press;
    logic                  r_long_done;

    logic                  n_last;
    logic [TIME_BITS-1:0]  n_change;
    logic                  n_held;
    logic [TIME_BITS-1:0]  n_press;
    logic                  n_long_done;

    // event register
    logic                  r_out_valid;
    bdpc_pkg::t_event      r_out_event;
    bdpc_pkg::t_event      n_event;

    logic                  w_fire;
    logic                  w_pressed;
    logic [TIME_BITS-1:0]  w_now;
    logic [TIME_BITS-1:0]  w_since_change;
    logic [TIME_BITS-1:0]  w_since_press;
    logic                  w_debouncing;
    logic                  w_long_due;

    assign w_fire      = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.ready && i_in_ch.valid) begin
            r_in_now <= i_in_ch.now_ms;
            r_in_pin <= i_in_ch.pin_level;
        end
    end

    assign w_pressed      = !r_in_pin;
    assign w_now          = TIME_BITS'(r_in_now);
    assign w_since_change = w_now - r_change;
    assign w_since_press  = w_now - r_press;
    assign w_debouncing   = w_since_change < TIME_BITS'(i_cfg.debounce_ms);
    assign w_long_due     = w_since_press >= TIME_BITS'(i_cfg.long_press_ms);

    always_comb begin
        n_last      = r_last;
        n_change    = r_change;
        n_held      = r_held;
        n_press     = r_press;
        n_long_done = r_long_done;
        n_event     = bdpc_pkg::EV_NONE;
        priority if (w_pressed != r_last) begin
            n_last   = w_pressed;
            n_change = w_now;
        end else if (w_debouncing) begin
            n_event = bdpc_pkg::EV_NONE;
        end else if (w_pressed && !r_held) begin
            n_held      = 1'b1;
            n_press     = w_now;
            n_long_done = 1'b0;
        end else if (w_pressed && !r_long_done && w_long_due) begin
            n_long_done = 1'b1;
            n_event     = bdpc_pkg::EV_LONG;
        end else if (!w_pressed && r_held) begin
            n_held  = 1'b0;
            n_event = r_long_done ? bdpc_pkg::EV_NONE : bdpc_pkg::EV_SHORT;
        end else begin
            n_event = bdpc_pkg::EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= 1'b0;
            r_change    <= '0;
            r_held      <= 1'b0;
            r_press     <= '0;
            r_long_done <= 1'b0;
        end else if (w_fire) begin
            r_last      <= n_last;
            r_change    <= n_change;
            r_held      <= n_held;
            r_press     <= n_press;
            r_long_done <= n_long_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_event <= n_event;
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.press_event = r_out_event;

`ifndef SYNTHESIS
    a_long_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_event == bdpc_pkg::EV_LONG) |=> (r_held && r_long_done))
        else $error("long press without held/done state");

    a_short_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_event == bdpc_pkg::EV_SHORT) |=> (!r_held && !r_long_done))
        else $error("short press left held state or followed a long press");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> ($stable(r_held) && $stable(r_long_done) && $stable(r_last)))
        else $error("classifier state changed without a beat");

    a_press_edge_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_held) |-> (!r_long_done && r_last))
        else $error("stable press edge with stale long flag");
`endif

endmodule

// ----- design/button_debounce_press_classifier.sv -----
// Top level of the button debounce and press classifier.
// Takes one poll (timestamp, active-low pin level) per cycle unless the event channel stalls,
// and returns one event beat per poll (none, short press, long press) via the poll register
// and then the event register. Classifier state registers update once per poll from two
// wrapping time subtract-compares. Config registers are to be written by the user through
// the plain write port while no poll is in flight; the block itself does not enforce this.
module button_debounce_press_classifier #(
    parameter int TIME_BITS = bdpc_pkg::TIME_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bdpc_pkg::CFG_W-1:0]        i_cfg_wdata,
    bdpc_in_if.sink                           i_in_ch,
    bdpc_out_if.source                        o_out_ch
);

    bdpc_pkg::t_cfg w_cfg;

    bdpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    bdpc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_in_ch  (i_in_ch),
        .o_out_ch (o_out_ch)
    );

endmodule
